// File: src/efc_pkg.sv
// ----------------------------------------------------------------------------
// efc_pkg
// Shared types and constants for the Ethernet/IPv4 flow counter.
// ----------------------------------------------------------------------------
package efc_pkg;

  // Request kinds on the input channel
  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Result kinds on the output channel
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_ENTRY   = 1'b1;

  // Ethertypes and IP protocols
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_ARP  = 16'h0806;
  localparam logic [15:0] ETH_RARP = 16'h8035;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [7:0]  PROTO_TCP = 8'd6;

  // Header byte offsets
  localparam logic [15:0] ETH_HDR_LEN  = 16'd14;
  localparam logic [15:0] IPV4_MIN_END = 16'd34;
  localparam logic [15:0] PORTS_END    = 16'd18;

  // Frame classes
  localparam logic [2:0] CLS_OTHER    = 3'd0;
  localparam logic [2:0] CLS_IPV4     = 3'd1;
  localparam logic [2:0] CLS_IPV4_UDP = 3'd2;
  localparam logic [2:0] CLS_IPV4_TCP = 3'd3;
  localparam logic [2:0] CLS_ARP      = 3'd4;
  localparam logic [2:0] CLS_RARP     = 3'd5;
  localparam logic [2:0] CLS_IPV6     = 3'd6;

  // Flow status codes
  localparam logic [2:0] FS_COUNTED  = 3'd0;
  localparam logic [2:0] FS_INSERTED = 3'd1;
  localparam logic [2:0] FS_FULL     = 3'd2;
  localparam logic [2:0] FS_NOT_IPV4 = 3'd3;
  localparam logic [2:0] FS_TRUNC    = 3'd4;

  typedef struct packed {
    logic       req_type;
    logic [7:0] frame_byte;
    logic       last_byte;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  frame_class;
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dest_ip;
    logic [15:0] src_port;
    logic [15:0] dest_port;
    logic [5:0]  flow_slot;
    logic [31:0] flow_total;
    logic [2:0]  flow_status;
  } out_item_t;

  // Header fields collected by the parser
  typedef struct packed {
    logic [15:0] byte_pos;
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
    logic [15:0] ethertype;
    logic [3:0]  header_len;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dest_ip;
    logic [15:0] src_port;
    logic [15:0] dest_port;
  } frame_info_t;

  // One flow table entry
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dest_ip;
    logic [31:0] count;
  } flow_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_INSERT,
    ST_RD_WAIT,
    ST_EMIT
  } seq_state_e;

endpackage

// File: src/efc_parser.sv
// ----------------------------------------------------------------------------
// efc_parser
// Byte-wise header capture: MACs, ethertype, IPv4 fields and L4 ports.
// ----------------------------------------------------------------------------
module efc_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [7:0]           byte_i,
  input  logic                 clear_i,
  output efc_pkg::frame_info_t info_o
);

  efc_pkg::frame_info_t info_d, info_q;

  // Field capture for the byte at the current position
  always_comb begin
    logic [15:0] p;
    logic [3:0]  ihl_now;
    logic [15:0] port_base;
    logic [2:0]  dmac_sel;
    logic [2:0]  smac_sel;
    logic [1:0]  sip_sel;
    logic [1:0]  dip_sel;
    p         = info_q.byte_pos;
    ihl_now   = (p == efc_pkg::ETH_HDR_LEN) ? byte_i[3:0] : info_q.header_len;
    port_base = efc_pkg::ETH_HDR_LEN + {10'd0, ihl_now, 2'b00};
    dmac_sel  = 3'(3'd5 - p[2:0]);
    smac_sel  = 3'(4'd11 - p[3:0]);
    sip_sel   = 2'(5'd29 - p[4:0]);
    dip_sel   = 2'(6'd33 - p[5:0]);
    info_d    = info_q;
    if (clear_i) begin
      info_d = '0;
    end else if (take_i) begin
      if (p < 16'd6) begin
        info_d.dest_mac[{dmac_sel, 3'b000} +: 8] = byte_i;
      end else if (p < 16'd12) begin
        info_d.src_mac[{smac_sel, 3'b000} +: 8] = byte_i;
      end else if (p == 16'd12) begin
        info_d.ethertype[15:8] = byte_i;
      end else if (p == 16'd13) begin
        info_d.ethertype[7:0] = byte_i;
      end
      // IPv4 header and ports once the ethertype is known
      if (p >= efc_pkg::ETH_HDR_LEN && info_q.ethertype == efc_pkg::ETH_IPV4) begin
        if (p == efc_pkg::ETH_HDR_LEN) begin
          info_d.header_len = byte_i[3:0];
        end else if (p == 16'd23) begin
          info_d.protocol = byte_i;
        end else if (p >= 16'd26 && p < 16'd30) begin
          info_d.src_ip[{sip_sel, 3'b000} +: 8] = byte_i;
        end else if (p >= 16'd30 && p < efc_pkg::IPV4_MIN_END) begin
          info_d.dest_ip[{dip_sel, 3'b000} +: 8] = byte_i;
        end
        if (p == port_base) begin
          info_d.src_port[15:8] = byte_i;
        end else if (p == port_base + 16'd1) begin
          info_d.src_port[7:0] = byte_i;
        end else if (p == port_base + 16'd2) begin
          info_d.dest_port[15:8] = byte_i;
        end else if (p == port_base + 16'd3) begin
          info_d.dest_port[7:0] = byte_i;
        end
      end
      // Position saturates on very long frames
      if (p != 16'hFFFF) begin
        info_d.byte_pos = p + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      info_q <= '0;
    end else begin
      info_q <= info_d;
    end
  end

  assign info_o = info_q;

endmodule

// File: src/efc_flow_mem.sv
// ----------------------------------------------------------------------------
// efc_flow_mem
// Flow table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module efc_flow_mem #(
  parameter int ENTRIES = 64
) (
  input  logic                       clk_i,
  input  logic                       re_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  output efc_pkg::flow_entry_t       rdata_o,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  efc_pkg::flow_entry_t       wdata_i
);

  efc_pkg::flow_entry_t mem_q [ENTRIES];
  efc_pkg::flow_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/efc_flow_seq.sv
// ----------------------------------------------------------------------------
// efc_flow_seq
// Sequencer that classifies a finished frame, walks the flow table one
// entry at a time through a shared compare, and builds the result item.
// ----------------------------------------------------------------------------
module efc_flow_seq #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  efc_pkg::in_item_t    item_i,
  input  efc_pkg::frame_info_t info_i,
  input  logic                 out_free_i,
  output logic                 busy_o,
  output logic                 emit_valid_o,
  output efc_pkg::out_item_t   emit_item_o,
  output logic                 parse_clear_o
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W  = (USED_W > 6) ? USED_W : 6;

  efc_pkg::seq_state_e state_d, state_q;
  logic [USED_W-1:0]   used_d, used_q;
  logic [IDX_W-1:0]    srch_d, srch_q;
  logic [5:0]          rd_idx_d, rd_idx_q;
  logic                rd_ok_d, rd_ok_q;
  efc_pkg::out_item_t  res_d, res_q;

  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  efc_pkg::flow_entry_t mem_rdata;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  efc_pkg::flow_entry_t mem_wdata;

  efc_flow_mem #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  // Frame classification from the captured header
  logic       is_ipv4, ported, trunc;
  logic [2:0] cls;

  always_comb begin
    logic long_enough;
    long_enough = (info_i.byte_pos >= efc_pkg::ETH_HDR_LEN);
    is_ipv4 = long_enough && (info_i.ethertype == efc_pkg::ETH_IPV4);
    ported  = is_ipv4 && (info_i.protocol == efc_pkg::PROTO_UDP ||
                          info_i.protocol == efc_pkg::PROTO_TCP);
    trunc   = !long_enough ||
              (is_ipv4 && (info_i.byte_pos < efc_pkg::IPV4_MIN_END ||
                (ported && info_i.byte_pos <
                   efc_pkg::PORTS_END + {10'd0, info_i.header_len, 2'b00})));
    cls = efc_pkg::CLS_OTHER;
    if (is_ipv4) begin
      if (info_i.protocol == efc_pkg::PROTO_UDP) begin
        cls = efc_pkg::CLS_IPV4_UDP;
      end else if (info_i.protocol == efc_pkg::PROTO_TCP) begin
        cls = efc_pkg::CLS_IPV4_TCP;
      end else begin
        cls = efc_pkg::CLS_IPV4;
      end
    end else if (long_enough) begin
      if (info_i.ethertype == efc_pkg::ETH_ARP) begin
        cls = efc_pkg::CLS_ARP;
      end else if (info_i.ethertype == efc_pkg::ETH_RARP) begin
        cls = efc_pkg::CLS_RARP;
      end else if (info_i.ethertype == efc_pkg::ETH_IPV6) begin
        cls = efc_pkg::CLS_IPV6;
      end
    end
  end

  // Shared compare unit against the entry just read
  logic match;
  assign match = (mem_rdata.src_ip == info_i.src_ip) &&
                 (mem_rdata.dest_ip == info_i.dest_ip);

  // Next state and outputs
  always_comb begin
    state_d       = state_q;
    used_d        = used_q;
    srch_d        = srch_q;
    rd_idx_d      = rd_idx_q;
    rd_ok_d       = rd_ok_q;
    res_d         = res_q;
    mem_re        = 1'b0;
    mem_raddr     = srch_q;
    mem_we        = 1'b0;
    mem_waddr     = srch_q;
    mem_wdata     = mem_rdata;
    emit_valid_o  = 1'b0;
    parse_clear_o = 1'b0;
    case (state_q)
      efc_pkg::ST_IDLE: begin
        if (take_i) begin
          if (item_i.req_type == efc_pkg::REQ_READ) begin
            mem_re    = 1'b1;
            mem_raddr = IDX_W'(item_i.read_index);
            rd_idx_d  = item_i.read_index;
            rd_ok_d   = CMP_W'(item_i.read_index) < CMP_W'(used_q);
            state_d   = efc_pkg::ST_RD_WAIT;
          end else if (item_i.last_byte) begin
            state_d = efc_pkg::ST_CLASSIFY;
          end
        end
      end
      efc_pkg::ST_CLASSIFY: begin
        res_d             = '0;
        res_d.result_kind = efc_pkg::KIND_SUMMARY;
        res_d.frame_class = cls;
        res_d.dest_mac    = info_i.dest_mac;
        res_d.src_mac     = info_i.src_mac;
        res_d.src_ip      = is_ipv4 ? info_i.src_ip : 32'd0;
        res_d.dest_ip     = is_ipv4 ? info_i.dest_ip : 32'd0;
        res_d.src_port    = ported ? info_i.src_port : 16'd0;
        res_d.dest_port   = ported ? info_i.dest_port : 16'd0;
        srch_d            = '0;
        if (trunc) begin
          res_d.flow_status = efc_pkg::FS_TRUNC;
          state_d           = efc_pkg::ST_EMIT;
        end else if (!is_ipv4) begin
          res_d.flow_status = efc_pkg::FS_NOT_IPV4;
          state_d           = efc_pkg::ST_EMIT;
        end else if (used_q == '0) begin
          state_d = efc_pkg::ST_INSERT;
        end else begin
          state_d = efc_pkg::ST_SRCH_RD;
        end
      end
      efc_pkg::ST_SRCH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = srch_q;
        state_d   = efc_pkg::ST_SRCH_CMP;
      end
      efc_pkg::ST_SRCH_CMP: begin
        if (match) begin
          // Saturating count update in place
          mem_we    = 1'b1;
          mem_waddr = srch_q;
          mem_wdata = mem_rdata;
          if (mem_rdata.count != 32'hFFFF_FFFF) begin
            mem_wdata.count = mem_rdata.count + 32'd1;
          end
          res_d.flow_slot   = 6'(srch_q);
          res_d.flow_total  = mem_wdata.count;
          res_d.flow_status = efc_pkg::FS_COUNTED;
          state_d           = efc_pkg::ST_EMIT;
        end else if (USED_W'(srch_q) + USED_W'(1) == used_q) begin
          state_d = efc_pkg::ST_INSERT;
        end else begin
          srch_d  = srch_q + IDX_W'(1);
          state_d = efc_pkg::ST_SRCH_RD;
        end
      end
      efc_pkg::ST_INSERT: begin
        if (used_q == USED_W'(TABLE_ENTRIES)) begin
          res_d.flow_status = efc_pkg::FS_FULL;
        end else begin
          mem_we            = 1'b1;
          mem_waddr         = IDX_W'(used_q);
          mem_wdata.src_ip  = info_i.src_ip;
          mem_wdata.dest_ip = info_i.dest_ip;
          mem_wdata.count   = 32'd1;
          res_d.flow_slot   = 6'(used_q);
          res_d.flow_total  = 32'd1;
          res_d.flow_status = efc_pkg::FS_INSERTED;
          used_d            = used_q + USED_W'(1);
        end
        state_d = efc_pkg::ST_EMIT;
      end
      efc_pkg::ST_RD_WAIT: begin
        res_d             = '0;
        res_d.result_kind = efc_pkg::KIND_ENTRY;
        res_d.flow_slot   = rd_idx_q;
        if (rd_ok_q) begin
          res_d.src_ip     = mem_rdata.src_ip;
          res_d.dest_ip    = mem_rdata.dest_ip;
          res_d.flow_total = mem_rdata.count;
        end
        state_d = efc_pkg::ST_EMIT;
      end
      efc_pkg::ST_EMIT: begin
        emit_valid_o = 1'b1;
        if (out_free_i) begin
          parse_clear_o = (res_q.result_kind == efc_pkg::KIND_SUMMARY);
          state_d       = efc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = efc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= efc_pkg::ST_IDLE;
      used_q  <= '0;
      srch_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      srch_q  <= srch_d;
    end
  end

  // Result and read request payload
  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    rd_idx_q <= rd_idx_d;
    rd_ok_q  <= rd_ok_d;
  end

  assign busy_o      = (state_q != efc_pkg::ST_IDLE);
  assign emit_item_o = res_q;

endmodule

// File: src/ethernet_ipv4_flow_counter.sv
// ----------------------------------------------------------------------------
// ethernet_ipv4_flow_counter
// Ethernet/IPv4 header parser with a source/destination flow counter.
// ----------------------------------------------------------------------------
// A frame byte that is not the last of its frame is taken without a stall
// and gives no result. After the last byte the input stalls while the
// frame is classified and compared with the entries up to and including a
// match; a frame that adds a new entry or finds the table full is compared
// with all entries in use, then passes the insert state; truncated and
// non-IPv4 frames skip the table. The table sits in one single-port-read
// memory and one shared comparator checks one entry at a time (address,
// then compare). A table read waits for the registered memory read. Results
// go into an output register, so the input side stays open for frame bytes
// while a result waits to be taken; the next result holds the input stalled
// only while that register is still full.
module ethernet_ipv4_flow_counter #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  efc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output efc_pkg::out_item_t out_item_o
);

  logic                 in_take;
  logic                 busy;
  logic                 emit_valid;
  efc_pkg::out_item_t   emit_item;
  logic                 parse_clear;
  logic                 out_free;
  efc_pkg::frame_info_t info;
  logic                 out_valid_d, out_valid_q;
  efc_pkg::out_item_t   out_q;

  assign in_stall_o = busy;
  assign in_take    = in_valid_i && !busy;

  efc_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (in_take && (in_item_i.req_type == efc_pkg::REQ_FRAME)),
    .byte_i  (in_item_i.frame_byte),
    .clear_i (parse_clear),
    .info_o  (info)
  );

  efc_flow_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (in_take),
    .item_i        (in_item_i),
    .info_i        (info),
    .out_free_i    (out_free),
    .busy_o        (busy),
    .emit_valid_o  (emit_valid),
    .emit_item_o   (emit_item),
    .parse_clear_o (parse_clear)
  );

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = emit_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid && out_free) begin
      out_q <= emit_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: tb/ethernet_ipv4_flow_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ethernet_ipv4_flow_counter_tb
// Feeds captured Ethernet frames byte by byte and flow table reads into the
// flow counter, tracks headers and the flow table on the side, and checks
// every frame summary and table entry that comes back, field by field.
// ----------------------------------------------------------------------------
module ethernet_ipv4_flow_counter_tb;

  localparam int FLOW_ENTRIES     = 64;
  localparam int QUIET_LIMIT      = 4000;   // cycles with no item moving
  localparam int TAIL_CYCLES      = 300;

  // Pending input item plus its pacing hints
  typedef struct {
    efc_pkg::in_item_t item;
    bit       drain_first;  // hold until every awaited result is back
    bit       no_gap;       // send back to back
  } stim_t;

  // Header fields collected from the frame in flight
  typedef struct packed {
    logic [15:0] pos;
    logic [47:0] dmac;
    logic [47:0] smac;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
  } hdr_track_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  efc_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  efc_pkg::out_item_t out_item_o;

  stim_t              backlog[$];
  efc_pkg::out_item_t due_records[$];
  logic [7:0]         frame_buf[$];
  logic [31:0]        addr_pool[4];

  // Side copy of the parser and flow table
  hdr_track_t  hdr = '0;
  logic [31:0] flow_src[FLOW_ENTRIES];
  logic [31:0] flow_dst[FLOW_ENTRIES];
  logic [31:0] flow_cnt[FLOW_ENTRIES];
  int          flows_in_use = 0;

  int mismatch_count = 0;
  int quiet_cycles = 0;
  int gap_left = -1;
  int stall_left = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  ethernet_ipv4_flow_counter #(
    .TABLE_ENTRIES(FLOW_ENTRIES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Header tracking and flow counting
  // --------------------------------------------------------------------------
  function automatic void absorb_frame_byte(logic [7:0] b);
    int p;
    int t;
    p = int'(hdr.pos);
    if (p < 6) hdr.dmac[8*(5-p) +: 8] = b;
    else if (p < 12) hdr.smac[8*(11-p) +: 8] = b;
    else if (p == 12) hdr.etype[15:8] = b;
    else if (p == 13) hdr.etype[7:0] = b;
    // IPv4 fields only once the ethertype is known
    if (p >= int'(efc_pkg::ETH_HDR_LEN) && hdr.etype == efc_pkg::ETH_IPV4) begin
      if (p == 14) hdr.ihl = b[3:0];
      else if (p == 23) hdr.proto = b;
      else if (p >= 26 && p < 30) hdr.sip[8*(29-p) +: 8] = b;
      else if (p >= 30 && p < 34) hdr.dip[8*(33-p) +: 8] = b;
      // transport header follows the IHL as given, even a tiny one
      t = int'(efc_pkg::ETH_HDR_LEN) + 4 * int'(hdr.ihl);
      if (p == t) hdr.sport[15:8] = b;
      else if (p == t + 1) hdr.sport[7:0] = b;
      else if (p == t + 2) hdr.dport[15:8] = b;
      else if (p == t + 3) hdr.dport[7:0] = b;
    end
    if (hdr.pos != 16'hFFFF) hdr.pos = hdr.pos + 16'd1;
  endfunction

  function automatic efc_pkg::out_item_t close_frame();
    efc_pkg::out_item_t r;
    int len;
    bit ipv4;
    bit ported;
    bit trunc;
    bit found;
    r = '0;
    r.result_kind = efc_pkg::KIND_SUMMARY;
    r.frame_class = efc_pkg::CLS_OTHER;
    r.flow_status = efc_pkg::FS_NOT_IPV4;
    len = int'(hdr.pos);
    ipv4 = 1'b0;
    ported = 1'b0;
    trunc = 1'b0;
    found = 1'b0;
    // classify on whatever arrived
    if (len < int'(efc_pkg::ETH_HDR_LEN)) begin
      trunc = 1'b1;
    end else if (hdr.etype == efc_pkg::ETH_IPV4) begin
      ipv4 = 1'b1;
      if (hdr.proto == efc_pkg::PROTO_UDP) begin
        r.frame_class = efc_pkg::CLS_IPV4_UDP;
        ported = 1'b1;
      end else if (hdr.proto == efc_pkg::PROTO_TCP) begin
        r.frame_class = efc_pkg::CLS_IPV4_TCP;
        ported = 1'b1;
      end else begin
        r.frame_class = efc_pkg::CLS_IPV4;
      end
      if (len < int'(efc_pkg::IPV4_MIN_END) ||
          (ported && len < int'(efc_pkg::PORTS_END) + 4 * int'(hdr.ihl))) trunc = 1'b1;
    end else if (hdr.etype == efc_pkg::ETH_ARP) begin
      r.frame_class = efc_pkg::CLS_ARP;
    end else if (hdr.etype == efc_pkg::ETH_RARP) begin
      r.frame_class = efc_pkg::CLS_RARP;
    end else if (hdr.etype == efc_pkg::ETH_IPV6) begin
      r.frame_class = efc_pkg::CLS_IPV6;
    end
    r.dest_mac = hdr.dmac;
    r.src_mac = hdr.smac;
    if (ipv4) begin
      r.src_ip = hdr.sip;
      r.dest_ip = hdr.dip;
    end
    if (ported) begin
      r.src_port = hdr.sport;
      r.dest_port = hdr.dport;
    end
    // flow lookup, then insert or report a full table
    if (trunc) begin
      r.flow_status = efc_pkg::FS_TRUNC;
    end else if (ipv4) begin
      for (int i = 0; i < flows_in_use; i++) begin
        if (!found && flow_src[i] == hdr.sip && flow_dst[i] == hdr.dip) begin
          if (flow_cnt[i] != '1) flow_cnt[i] = flow_cnt[i] + 32'd1;
          r.flow_slot = 6'(i);
          r.flow_total = flow_cnt[i];
          r.flow_status = efc_pkg::FS_COUNTED;
          found = 1'b1;
        end
      end
      if (!found) begin
        if (flows_in_use >= FLOW_ENTRIES) begin
          r.flow_status = efc_pkg::FS_FULL;
        end else begin
          flow_src[flows_in_use] = hdr.sip;
          flow_dst[flows_in_use] = hdr.dip;
          flow_cnt[flows_in_use] = 32'd1;
          r.flow_slot = 6'(flows_in_use);
          r.flow_total = 32'd1;
          r.flow_status = efc_pkg::FS_INSERTED;
          flows_in_use++;
        end
      end
    end
    hdr = '0;
    return r;
  endfunction

  function automatic void parse_and_count(efc_pkg::in_item_t it);
    efc_pkg::out_item_t r;
    if (it.req_type == efc_pkg::REQ_READ) begin
      r = '0;
      r.result_kind = efc_pkg::KIND_ENTRY;
      r.flow_slot = it.read_index;
      if (int'(it.read_index) < flows_in_use) begin
        r.src_ip = flow_src[it.read_index];
        r.dest_ip = flow_dst[it.read_index];
        r.flow_total = flow_cnt[it.read_index];
      end
      due_records.push_back(r);
    end else begin
      absorb_frame_byte(it.frame_byte);
      if (it.last_byte) due_records.push_back(close_frame());
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    if (mismatch_count < 100) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [63:0] seen, logic [63:0] want);
    if (seen !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, seen, want));
  endtask

  task automatic check_record(efc_pkg::out_item_t got);
    efc_pkg::out_item_t want;
    if (due_records.size() == 0) begin
      report_mismatch("result arrived with nothing awaited");
      return;
    end
    want = due_records.pop_front();
    check_field("result_kind", 64'(got.result_kind), 64'(want.result_kind));
    check_field("frame_class", 64'(got.frame_class), 64'(want.frame_class));
    check_field("dest_mac", 64'(got.dest_mac), 64'(want.dest_mac));
    check_field("src_mac", 64'(got.src_mac), 64'(want.src_mac));
    check_field("src_ip", 64'(got.src_ip), 64'(want.src_ip));
    check_field("dest_ip", 64'(got.dest_ip), 64'(want.dest_ip));
    check_field("src_port", 64'(got.src_port), 64'(want.src_port));
    check_field("dest_port", 64'(got.dest_port), 64'(want.dest_port));
    check_field("flow_slot", 64'(got.flow_slot), 64'(want.flow_slot));
    check_field("flow_total", 64'(got.flow_total), 64'(want.flow_total));
    check_field("flow_status", 64'(got.flow_status), 64'(want.flow_status));
  endtask

  // Wait length per item; calm stretches send back to back
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one item per handshake from the backlog
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : feed
    bit holding;
    bit launch;
    stim_t next_stim;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i <= '0;
    end else begin
      holding = in_valid_i;
      launch = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        parse_and_count(in_item_i);
        holding = 1'b0;
      end
      if (!holding && backlog.size() != 0 &&
          !(backlog[0].drain_first && due_records.size() != 0)) begin
        if (gap_left < 0) gap_left = backlog[0].no_gap ? 0 : draw_wait(in_calm);
        if (gap_left == 0) begin
          next_stim = backlog.pop_front();
          launch = 1'b1;
          gap_left = -1;
        end else begin
          gap_left--;
        end
      end
      in_valid_i <= holding || launch;
      if (launch) in_item_i <= next_stim.item;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes results with random stalls
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : take_results
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_record(out_item_o);
        stall_left = draw_wait(out_calm);
      end else if (out_valid_o && stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Watchdog on cycles where nothing moves
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ethernet_ipv4_flow_counter_tb: errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Frame building
  // --------------------------------------------------------------------------
  function automatic void begin_frame(logic [47:0] dmac, logic [47:0] smac,
                                      logic [15:0] etype);
    frame_buf.delete();
    for (int i = 5; i >= 0; i--) frame_buf.push_back(dmac[8*i +: 8]);
    for (int i = 5; i >= 0; i--) frame_buf.push_back(smac[8*i +: 8]);
    frame_buf.push_back(etype[15:8]);
    frame_buf.push_back(etype[7:0]);
  endfunction

  function automatic void add_filler(int n);
    for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom));
  endfunction

  // IPv4 header with options padded up to the IHL
  function automatic void add_ipv4(logic [3:0] version, logic [3:0] ihl, logic [7:0] proto,
                                   logic [31:0] sip, logic [31:0] dip);
    frame_buf.push_back({version, ihl});
    add_filler(8);
    frame_buf.push_back(proto);
    add_filler(2);
    for (int i = 3; i >= 0; i--) frame_buf.push_back(sip[8*i +: 8]);
    for (int i = 3; i >= 0; i--) frame_buf.push_back(dip[8*i +: 8]);
    while (frame_buf.size() < int'(efc_pkg::ETH_HDR_LEN) + 4 * int'(ihl))
      frame_buf.push_back(8'($urandom));
  endfunction

  function automatic void add_ports(logic [15:0] sport, logic [15:0] dport);
    frame_buf.push_back(sport[15:8]);
    frame_buf.push_back(sport[7:0]);
    frame_buf.push_back(dport[15:8]);
    frame_buf.push_back(dport[7:0]);
  endfunction

  // Ships the first keep bytes (all when keep is 0); returns the count
  function automatic int ship_frame(int keep, bit drain, bit burst);
    stim_t s;
    if (keep <= 0 || keep > frame_buf.size()) keep = frame_buf.size();
    for (int i = 0; i < keep; i++) begin
      s.item.req_type = efc_pkg::REQ_FRAME;
      s.item.frame_byte = frame_buf[i];
      s.item.last_byte = (i == keep - 1);
      s.item.read_index = 6'($urandom);
      s.drain_first = drain && (i == 0);
      s.no_gap = burst;
      backlog.push_back(s);
    end
    return keep;
  endfunction

  function automatic void queue_read(logic [5:0] idx, bit drain);
    stim_t s;
    s.item.req_type = efc_pkg::REQ_READ;
    s.item.frame_byte = 8'($urandom);
    s.item.last_byte = 1'($urandom);
    s.item.read_index = idx;
    s.drain_first = drain;
    s.no_gap = 1'b0;
    backlog.push_back(s);
  endfunction

  function automatic logic [47:0] any_mac();
    return 48'({$urandom, $urandom});
  endfunction

  // Mostly well-formed IPv4 over a small address pool, some reads and junk
  function automatic void random_traffic(int byte_goal, int record_goal);
    int bytes_done;
    int records_done;
    int pick;
    int keep;
    bit drain;
    logic [3:0] ihl;
    logic [7:0] proto;
    logic [15:0] etype;
    logic [31:0] sip;
    bytes_done = 0;
    records_done = 0;
    while (bytes_done < byte_goal || records_done < record_goal) begin
      pick = $urandom_range(0, 99);
      drain = ($urandom_range(0, 39) == 0);
      keep = 0;
      if (pick < 10) begin
        queue_read(6'($urandom), drain);
      end else if (pick < 75) begin
        case ($urandom_range(0, 19))
          0, 1, 2:  proto = 8'($urandom);
          3, 4, 5, 6, 7, 8, 9, 10: proto = efc_pkg::PROTO_TCP;
          default: proto = efc_pkg::PROTO_UDP;
        endcase
        ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
        sip = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 3)];
        begin_frame(any_mac(), any_mac(), efc_pkg::ETH_IPV4);
        add_ipv4(($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd4, ihl, proto,
                 sip, addr_pool[$urandom_range(0, 3)]);
        add_ports(16'($urandom), 16'($urandom));
        add_filler($urandom_range(0, 10));
        if ($urandom_range(0, 7) == 0) keep = $urandom_range(1, frame_buf.size());
        bytes_done += ship_frame(keep, drain, 1'b0);
      end else begin
        case ($urandom_range(0, 4))
          0: etype = efc_pkg::ETH_ARP;
          1: etype = efc_pkg::ETH_RARP;
          2: etype = efc_pkg::ETH_IPV6;
          3: etype = efc_pkg::ETH_IPV4;
          default: etype = 16'($urandom);
        endcase
        begin_frame(any_mac(), any_mac(), etype);
        add_filler($urandom_range(0, 50));
        if ($urandom_range(0, 1) == 0) keep = $urandom_range(1, frame_buf.size());
        bytes_done += ship_frame(keep, drain, 1'b0);
      end
      records_done++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : main
    int unused;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = $urandom;
    addr_pool[3] = $urandom;

    // empty table read
    queue_read(6'd0, 1'b0);
    // runt frames, the shortest one a single byte
    begin_frame('1, '1, 16'hFFFF);
    unused = ship_frame(1, 1'b0, 1'b0);
    unused = ship_frame(13, 1'b0, 1'b0);
    // ethertype cut after its first byte, then an IPv4 frame with no IP header
    begin_frame(any_mac(), any_mac(), efc_pkg::ETH_IPV4);
    unused = ship_frame(13, 1'b0, 1'b0);
    unused = ship_frame(14, 1'b0, 1'b0);
    // non-IPv4 classes
    begin_frame('1, '0, efc_pkg::ETH_ARP);
    add_filler(28);
    unused = ship_frame(0, 1'b0, 1'b0);
    begin_frame('0, '1, efc_pkg::ETH_RARP);
    add_filler(28);
    unused = ship_frame(0, 1'b0, 1'b0);
    begin_frame(any_mac(), any_mac(), efc_pkg::ETH_IPV6);
    add_filler(40);
    unused = ship_frame(0, 1'b0, 1'b0);
    begin_frame(any_mac(), any_mac(), 16'hFFFF);
    add_filler(46);
    unused = ship_frame(0, 1'b1, 1'b0);
    // UDP with all-ones fields, twice so the second one is counted
    begin_frame('1, '1, efc_pkg::ETH_IPV4);
    add_ipv4(4'd4, 4'd5, efc_pkg::PROTO_UDP, '1, '1);
    add_ports('1, '1);
    unused = ship_frame(0, 1'b0, 1'b0);
    unused = ship_frame(0, 1'b0, 1'b0);
    // TCP with all-zero fields, other protocol
    begin_frame('0, '0, efc_pkg::ETH_IPV4);
    add_ipv4(4'd4, 4'd5, efc_pkg::PROTO_TCP, '0, '0);
    add_ports('0, '0);
    add_filler(6);
    unused = ship_frame(0, 1'b0, 1'b0);
    begin_frame(any_mac(), any_mac(), efc_pkg::ETH_IPV4);
    add_ipv4(4'd4, 4'd5, 8'hFF, addr_pool[2], addr_pool[3]);
    unused = ship_frame(0, 1'b0, 1'b0);
    // IPv4 ending inside the addresses, UDP ending inside the ports
    begin_frame(any_mac(), any_mac(), efc_pkg::ETH_IPV4);
    add_ipv4(4'd4, 4'd5, efc_pkg::PROTO_UDP, addr_pool[3], addr_pool[2]);
    add_ports(16'h1234, 16'h5678);
    unused = ship_frame(30, 1'b0, 1'b0);
    unused = ship_frame(36, 1'b0, 1'b0);
    // largest IHL: ports behind 40 option bytes
    begin_frame(any_mac(), any_mac(), efc_pkg::ETH_IPV4);
    add_ipv4(4'd4, 4'd15, efc_pkg::PROTO_TCP, addr_pool[2], addr_pool[2]);
    add_ports(16'hABCD, 16'h00FF);
    unused = ship_frame(0, 1'b0, 1'b0);
    // IHL zero: version byte doubles as the high source port byte
    begin_frame(any_mac(), any_mac(), efc_pkg::ETH_IPV4);
    add_ipv4(4'd4, 4'd0, efc_pkg::PROTO_UDP, addr_pool[3], addr_pool[3]);
    add_filler(2);
    unused = ship_frame(0, 1'b0, 1'b0);
    // small IHL: ports overlap the IP header
    begin_frame(any_mac(), any_mac(), efc_pkg::ETH_IPV4);
    add_ipv4(4'hF, 4'd2, efc_pkg::PROTO_UDP, addr_pool[0], addr_pool[1]);
    unused = ship_frame(0, 1'b0, 1'b0);
    // entries in use and past the end
    queue_read(6'd0, 1'b1);
    queue_read(6'd1, 1'b0);
    queue_read(6'd4, 1'b0);
    queue_read(6'd63, 1'b0);

    random_traffic(200, 6);

    // sweep over the low table entries
    for (int i = 0; i < 8; i++) queue_read(6'(i), i == 0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (backlog.size() != 0 || in_valid_i || due_records.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (due_records.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_records.size()));

    if (mismatch_count == 0) begin
      $display("ethernet_ipv4_flow_counter_tb: clean");
    end else begin
      $display("ethernet_ipv4_flow_counter_tb: errors");
    end
    $finish;
  end

endmodule
